// ===== rtl/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 package
// Shared types and constants for the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef enum logic {
    FUNC_ABSORB = 1'b0,
    FUNC_FINISH = 1'b1
  } func_t;

  typedef struct packed {
    logic       func;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) begin
      k = K0;
    end else if (r < 7'd40) begin
      k = K1;
    end else if (r < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      f = b ^ c ^ d;
    end else if (r < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

// ===== rtl/sha1_queue.sv =====
// ----------------------------------------------------------------------------
// SHA-1 item queue
// Small register FIFO between the front end and the hashing engine.
// ----------------------------------------------------------------------------
module sha1_queue
  import sha1_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t push_data,
  output logic     full,
  input  logic     pop,
  output in_item_t pop_data,
  output logic     empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  in_item_t       mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;

  assign full     = (count == (AW+1)'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end

endmodule

// ===== rtl/sha1_engine.sv =====
// ----------------------------------------------------------------------------
// SHA-1 engine
// Packs bytes into a 16-word schedule window, runs one round per cycle,
// handles padding and streams the digest out through an output register.
// ----------------------------------------------------------------------------
module sha1_engine
  import sha1_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  in_item_t  item,
  output logic      item_pop,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_stall
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_PAD,
    S_EMIT
  } state_t;

  state_t      state;
  logic [31:0] w [16];
  logic [5:0]  pending;
  logic [63:0] msg_bits;
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [6:0]  round;
  logic        finishing;
  logic        second_pad;
  logic [63:0] total;
  logic [2:0]  emit_idx;

  logic [31:0] w_new;
  logic [31:0] w_cur;
  logic [31:0] t_val;
  logic [31:0] w_sched;

  assign w_cur   = w[0];
  assign w_sched = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign w_new   = {w_sched[30:0], w_sched[31]};
  assign t_val   = {a[26:0], a[31:27]} + round_f(round, b, c, d) + e + round_k(round) + w_cur;

  assign item_pop = (state == S_IDLE) && item_valid;

  // Build a padded block in w from pending bytes (already placed in w).
  function automatic logic [31:0] pad_word(input logic [31:0] wv, input logic [3:0] wi,
                                           input logic [5:0] n, input logic [63:0] tot,
                                           input logic add_len, input logic keep);
    logic [31:0] r;
    logic [5:0]  base;
    r = wv;
    for (int j = 0; j < 4; j++) begin
      base = {wi, 2'(j)};
      if (!keep || base > n) begin
        r[31-8*j -: 8] = 8'h00;
      end else if (base == n) begin
        r[31-8*j -: 8] = PAD_BYTE;
      end
    end
    if (add_len && wi == 4'd14) begin
      r = tot[63:32];
    end
    if (add_len && wi == 4'd15) begin
      r = tot[31:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pending   <= '0;
      msg_bits  <= '0;
      h[0] <= H0_INIT; h[1] <= H1_INIT; h[2] <= H2_INIT; h[3] <= H3_INIT; h[4] <= H4_INIT;
      round     <= '0;
      finishing <= 1'b0;
      second_pad <= 1'b0;
      emit_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (item.func == FUNC_ABSORB) begin
              w[pending[5:2]][31-8*pending[1:0] -: 8] <= item.byte_value;
              pending <= pending + 6'd1;
              if (pending == 6'd63) begin
                state <= S_ROUND;
                round <= '0;
                finishing <= 1'b0;
                a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
              end
            end else begin
              total <= msg_bits + {55'd0, pending, 3'd0};
              finishing <= 1'b1;
              second_pad <= (pending >= 6'd56);
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          for (int i = 0; i < 16; i++) begin
            w[i] <= pad_word(w[i], 4'(i), pending, total, !second_pad, 1'b1);
          end
          state <= S_ROUND;
          round <= '0;
          a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) begin
            w[i] <= w[i+1];
          end
          w[15] <= w_new;
          e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= t_val;
          round <= round + 7'd1;
          if (round == 7'd79) begin
            h[0] <= h[0] + t_val;
            h[1] <= h[1] + a;
            h[2] <= h[2] + {b[1:0], b[31:2]};
            h[3] <= h[3] + c;
            h[4] <= h[4] + d;
            if (!finishing) begin
              msg_bits <= msg_bits + 64'd512;
              pending <= '0;
              state <= S_IDLE;
            end else if (second_pad) begin
              second_pad <= 1'b0;
              for (int i = 0; i < 16; i++) begin
                w[i] <= pad_word(32'd0, 4'(i), pending, total, 1'b1, 1'b0);
              end
              state <= S_PAD;
              pending <= 6'd63;
            end else begin
              state <= S_EMIT;
              emit_idx <= '0;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            if (emit_idx == 3'd5) begin
              out_valid <= 1'b0;
              state <= S_IDLE;
              pending <= '0;
              msg_bits <= '0;
              finishing <= 1'b0;
              h[0] <= H0_INIT; h[1] <= H1_INIT; h[2] <= H2_INIT;
              h[3] <= H3_INIT; h[4] <= H4_INIT;
            end else begin
              out_valid <= 1'b1;
              out_item.digest_word <= h[emit_idx];
              out_item.word_index <= emit_idx;
              out_item.last_word <= (emit_idx == 3'd4);
              emit_idx <= emit_idx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/sha1_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Front queue takes byte and finish beats; the engine packs bytes, runs
// 80 rounds per block and emits five digest words per finish.
// ----------------------------------------------------------------------------
// channel  direction  payload      handshake
// in       input      in_item_t    in_valid / in_stall
// out      output     out_item_t   out_valid / out_stall
//
// An absorb beat is taken whenever the engine is idle; every 64th byte starts
// a block of rounds (one round per cycle on the single round unit).
// A finish runs padding and rounds for one or two blocks, then 5 output beats.
// The input queue keeps taking beats while the engine runs, until it fills.
// Reset is synchronous on rst and restores the initial chaining values.
module sha1_byte_stream_hasher
  import sha1_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      in_stall,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);

  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  in_item_t q_item;

  assign in_stall = q_full;

  sha1_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst,
    .push(in_valid), .push_data(in_data), .full(q_full),
    .pop(q_pop), .pop_data(q_item), .empty(q_empty)
  );

  sha1_engine u_engine (
    .clk, .rst,
    .item_valid(!q_empty), .item(q_item), .item_pop(q_pop),
    .out_valid, .out_item(out_data), .out_stall
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output changed");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.word_index <= 3'd4)
    else $error("word index out of range");

  a_last_word: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd4)))
    else $error("last word flag mismatch");

endmodule
